// ===== design/annexb_nal_unit_splitter_assert.svh =====
// Assertion macros for the Annex B NAL unit splitter checker.
// No dependencies; included by the checker file only.
`ifndef ANNEXB_NAL_UNIT_SPLITTER_ASSERT_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_ASSERT_SVH

// Concurrent property check, disabled while rstn is low.
`define ANBS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Expression that must never be true, disabled while rstn is low.
`define ANBS_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`endif

// ===== design/anbs_pkg.sv =====
// Shared types and constants for the Annex B NAL unit splitter.
// No dependencies.
`default_nettype none

package anbs_pkg;

    localparam logic [4:0] TYPE_IDR = 5'd5;
    localparam logic [4:0] TYPE_SPS = 5'd7;
    localparam logic [4:0] TYPE_PPS = 5'd8;
    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [9:0] INTERVAL_RESET = 10'(1000 / 25);
    localparam logic [23:0] LEN_OUT_MAX = 24'hffffff;
    localparam logic [2:0] MAX_OUT = 3'd4;

    // Bytes released by one input byte, for the back end to send out.
    typedef struct packed {
        logic [3:0][7:0] data;   // data[0] goes out first
        logic [2:0]      cnt;    // 0..4 bytes
        logic            ends;   // last byte sent closes the unit
        logic            eos;    // stream ends after these bytes
        logic [4:0]      utype;
    } seg_t;

endpackage

`default_nettype wire

// ===== design/annexb_nal_unit_splitter.sv =====
// Annex B NAL unit splitter: one stream byte per cycle in while the 4-deep queue has room.
// A released byte is held in the queue, then in the output register, before it is on m_.
// Throughput: the back end sends one byte per cycle while m_tready allows; an input byte
// releases 0 to 4 bytes; an end-of-stream byte with nothing to flush sends no byte.
// Reset (aresetn low, synchronous): stream state cleared, frame interval back to 40 ms.
// Top level; uses anbs_pkg, anbs_front, anbs_queue and anbs_back.
`default_nettype none

module annexb_nal_unit_splitter #(
    parameter int LENGTH_BITS = 24,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [9:0]  cfg_data,    // frame_interval_ms
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] data_byte
    input  wire logic        s_tlast,     // end_of_stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,     // [7:0] payload_byte, [39:8] timestamp_ms,
                                          // [63:40] unit_length
    output logic [7:0]       m_tuser,     // [4:0] unit_type, [5] first_of_unit,
                                          // [6] is_keyframe, [7] is_parameter_set
    output logic             m_tlast      // last_of_unit
);
    import anbs_pkg::*;

    logic push_valid, push_ready, pop_valid, pop_ready;
    seg_t push_seg, pop_seg;

    assign cfg_ready = 1'b1;

    anbs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_seg   (push_seg)
    );

    anbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_seg   (push_seg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_seg    (pop_seg)
    );

    anbs_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .head_valid (pop_valid),
        .head_pop   (pop_ready),
        .head_seg   (pop_seg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// ===== design/anbs_front.sv =====
// Front end: start code detection and byte classification.
// Uses anbs_pkg; feeds segment records to anbs_queue.
`default_nettype none

module anbs_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,    // [7:0] data_byte
    input  wire logic          s_tlast,    // end_of_stream
    output logic               push_valid,
    input  wire logic          push_ready,
    output anbs_pkg::seg_t     push_seg
);
    import anbs_pkg::*;

    logic [7:0] pb_reg, pb_next;
    logic       pv_reg, pv_next;
    logic [1:0] pc_reg, pc_next;
    logic       in_unit_reg, in_unit_next;
    logic [4:0] type_reg, type_next;

    logic       accept, is_zero, start, eos;
    logic       lead, tail, emit_any;
    logic [2:0] z, n, lz;
    logic [4:0] type_now;

    assign s_tready = push_ready;
    assign accept   = s_tvalid && s_tready;
    assign eos      = s_tlast;
    assign is_zero  = (s_tdata == 8'h00);
    assign start    = (s_tdata == START_BYTE) && pc_reg[1];

    always_comb begin
        pb_next      = pb_reg;
        pv_next      = pv_reg;
        pc_next      = pc_reg;
        in_unit_next = in_unit_reg;
        type_next    = type_reg;
        type_now     = type_reg;
        lead         = 1'b0;
        tail         = 1'b0;
        emit_any     = 1'b0;
        z            = 3'd0;
        n            = 3'd0;
        lz           = 3'd0;
        push_valid   = 1'b0;
        push_seg     = '0;
        if (accept) begin
            if (!in_unit_reg) begin
                if (start) begin
                    in_unit_next = 1'b1;
                    pv_next      = 1'b0;
                    pc_next      = 2'd0;
                end else if (is_zero) begin
                    pc_next = (pc_reg == 2'd3) ? 2'd3 : pc_reg + 2'd1;
                end else begin
                    pc_next = 2'd0;
                end
            end else begin
                if (!pv_reg && pc_reg == 2'd0) begin
                    type_now = s_tdata[4:0];
                end
                type_next = type_now;
                if (start) begin
                    emit_any = 1'b1;
                end else if (is_zero) begin
                    if (pc_reg != 2'd3) begin
                        pc_next = pc_reg + 2'd1;
                        if (eos) begin
                            emit_any = 1'b1;
                            z        = {1'b0, pc_reg} + 3'd1;
                        end
                    end else begin
                        emit_any = 1'b1;
                        pb_next  = 8'h00;
                        pv_next  = 1'b1;
                        if (eos) begin
                            z = 3'd4;
                        end
                    end
                end else begin
                    emit_any = 1'b1;
                    z        = {1'b0, pc_reg};
                    tail     = eos;
                    pb_next  = s_tdata;
                    pv_next  = 1'b1;
                    pc_next  = 2'd0;
                end
                if (start) begin
                    in_unit_next = 1'b1;
                    pv_next      = 1'b0;
                    pc_next      = 2'd0;
                end
                lead = emit_any && pv_reg;
                lz   = {2'b00, lead} + z;
                n    = lz + {2'b00, tail};
                push_seg.cnt   = (n > MAX_OUT) ? MAX_OUT : n;
                push_seg.ends  = start || eos;
                push_seg.eos   = eos;
                push_seg.utype = type_now;
                for (int i = 0; i < 4; i++) begin
                    if (3'(i) < {2'b00, lead}) begin
                        push_seg.data[i] = pb_reg;
                    end else if (3'(i) < lz) begin
                        push_seg.data[i] = 8'h00;
                    end else begin
                        push_seg.data[i] = s_tdata;
                    end
                end
                push_valid = (n != 3'd0) || eos;
            end
            if (eos) begin
                in_unit_next = 1'b0;
                pb_next      = 8'h00;
                pv_next      = 1'b0;
                pc_next      = 2'd0;
                type_next    = 5'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pb_reg      <= 8'h00;
            pv_reg      <= 1'b0;
            pc_reg      <= 2'd0;
            in_unit_reg <= 1'b0;
            type_reg    <= 5'd0;
        end else begin
            pb_reg      <= pb_next;
            pv_reg      <= pv_next;
            pc_reg      <= pc_next;
            in_unit_reg <= in_unit_next;
            type_reg    <= type_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/anbs_queue.sv =====
// Short FIFO of segment records between front and back end.
// Uses anbs_pkg for the record type.
`default_nettype none

module anbs_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire anbs_pkg::seg_t push_seg,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output anbs_pkg::seg_t      pop_seg
);
    import anbs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    seg_t           mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_seg    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_seg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/anbs_back.sv =====
// Back end: sends bytes one per cycle unless stalled, with unit tags, length and
// timestamp. Uses anbs_pkg; drains anbs_queue and owns the output register.
`default_nettype none

module anbs_back #(
    parameter int LENGTH_BITS = 24
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_valid,
    input  wire logic [9:0]     cfg_data,
    input  wire logic           head_valid,
    output logic                head_pop,
    input  wire anbs_pkg::seg_t head_seg,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [63:0]         m_tdata,
    output logic [7:0]          m_tuser,
    output logic                m_tlast
);
    import anbs_pkg::*;

    localparam int CW = (LENGTH_BITS > 24) ? LENGTH_BITS : 24;

    logic [1:0]             idx_reg, idx_next;
    logic                   first_reg, first_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next, len_inc;
    logic [31:0]            ts_reg, ts_next;
    logic [9:0]             ivl_reg;
    logic                   valid_reg, valid_next;
    logic [63:0]            data_reg, data_next;
    logic [7:0]             user_reg, user_next;
    logic                   last_reg, last_next;

    logic                   can_load, last_pos, last, ps, idr;
    logic [CW-1:0]          len_ext;
    logic [23:0]            len_out;

    assign can_load = !valid_reg || m_tready;
    assign ps       = (head_seg.utype == TYPE_SPS) || (head_seg.utype == TYPE_PPS);
    assign idr      = (head_seg.utype == TYPE_IDR);
    assign last_pos = ({1'b0, idx_reg} == head_seg.cnt - 3'd1);
    assign last     = head_seg.ends && last_pos;
    assign len_inc  = (len_reg == '1) ? len_reg : len_reg + LENGTH_BITS'(1);
    assign len_ext  = CW'(len_inc);
    assign len_out  = (len_ext > CW'(LEN_OUT_MAX)) ? LEN_OUT_MAX : len_ext[23:0];

    always_comb begin
        idx_next   = idx_reg;
        first_next = first_reg;
        len_next   = len_reg;
        ts_next    = ts_reg;
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        head_pop   = 1'b0;
        if (head_valid) begin
            if (head_seg.cnt == 3'd0) begin
                head_pop = 1'b1;
                if (head_seg.eos) begin
                    ts_next = 32'd0;
                end
            end else if (can_load) begin
                valid_next = 1'b1;
                data_next  = {(last ? len_out : 24'd0), ts_reg, head_seg.data[idx_reg]};
                user_next  = {ps, idr, first_reg, head_seg.utype};
                last_next  = last;
                first_next = last;
                len_next   = last ? '0 : len_inc;
                if (last && !ps) begin
                    ts_next = ts_reg + 32'(ivl_reg);
                end
                if (last_pos) begin
                    head_pop = 1'b1;
                    idx_next = 2'd0;
                    if (head_seg.eos) begin
                        ts_next = 32'd0;
                    end
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            first_reg <= 1'b1;
            len_reg   <= '0;
            ts_reg    <= 32'd0;
            ivl_reg   <= INTERVAL_RESET;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            first_reg <= first_next;
            len_reg   <= len_next;
            ts_reg    <= ts_next;
            valid_reg <= valid_next;
            if (cfg_valid) begin
                ivl_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ===== design/anbs_checker.sv =====
// Port-level checker for the splitter output stream, bound to the top level.
// Uses the macros in annexb_nal_unit_splitter_assert.svh.
`default_nettype none

`include "annexb_nal_unit_splitter_assert.svh"

module anbs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [7:0]  m_tuser,
    input wire logic        m_tlast
);
    logic        after_last_reg;
    logic [31:0] ts_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_last_reg <= 1'b1;
            ts_seen_reg    <= 32'd0;
        end else if (m_tvalid && m_tready) begin
            after_last_reg <= m_tlast;
            ts_seen_reg    <= m_tdata[39:8];
        end
    end

    `ANBS_ASSERT(a_reset_clears_valid, aclk, 1'b1, !aresetn |=> !m_tvalid, "m_tvalid after reset")
    `ANBS_ASSERT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled transfer changed")
    `ANBS_ASSERT(a_first_follows_last, aclk, aresetn, m_tvalid |-> (m_tuser[5] == after_last_reg), "first mark not right after last")
    `ANBS_ASSERT(a_ts_steady_in_unit, aclk, aresetn, m_tvalid && !after_last_reg |-> (m_tdata[39:8] == ts_seen_reg), "timestamp changed inside unit")
    `ANBS_NEVER(a_len_only_on_last, aclk, aresetn, m_tvalid && !m_tlast && (m_tdata[63:40] != 24'd0), "length on non-last byte")

endmodule

bind annexb_nal_unit_splitter anbs_checker u_anbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
